// File: rtl/hllu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hllu_pkg
// shared widths, defaults and the front-to-back queue entry type
// ----------------------------------------------------------------------------
package hllu_pkg;

  localparam int HASH_W       = 64;
  localparam int RANK_W       = 6;
  localparam int BKT_OUT_W    = 14;
  localparam int CNT_W        = 32;
  localparam int PREC_DEFAULT = 14;
  localparam int PREC_MAX     = 18;
  localparam int GRP_W        = 8;
  localparam int GRP_N        = HASH_W / GRP_W;

  // classified item waiting for the register store
  typedef struct packed {
    logic [PREC_MAX-1:0] bucket;
    logic [RANK_W-1:0]   rank;
  } hllu_entry_t;

endpackage

// File: rtl/hllu_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hllu_front
// accepts hashes, splits bucket and computes the capped leading-zero rank
// ----------------------------------------------------------------------------
module hllu_front import hllu_pkg::*; #(
  parameter int Precision = PREC_DEFAULT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept_en,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [HASH_W-1:0] in_hash_value,
  output logic              q_valid,
  input  logic              q_ready,
  output hllu_entry_t       q_entry
);

  localparam int CntW = $clog2(HASH_W + 2);
  localparam logic [CntW-1:0] RankCap = CntW'(HASH_W + 1 - Precision);

  logic                 s0_valid_r;
  logic [HASH_W-1:0]    s0_hash_r;
  logic                 s0_take;
  logic [HASH_W-1:0]    shifted;
  logic [3:0]           grp_lz [GRP_N];

  logic                 s1_valid_r;
  logic                 s1_ready;
  logic [3:0]           s1_grp_lz_r [GRP_N];
  logic [Precision-1:0] s1_bucket_r;
  logic [CntW-1:0]      lz_total;
  logic [CntW-1:0]      rank_sum;
  logic [RANK_W-1:0]    rank;

  assign s0_take  = !s0_valid_r || s1_ready;
  assign in_ready = accept_en && s0_take;
  assign s1_ready = !s1_valid_r || q_ready;
  assign shifted  = s0_hash_r << Precision;

  // per-byte leading zeros, top byte first
  always_comb begin
    logic found;
    for (int g = 0; g < GRP_N; g++) begin
      found     = 1'b0;
      grp_lz[g] = '0;
      for (int i = 0; i < GRP_W; i++) begin
        if (!found && !shifted[HASH_W-1-GRP_W*g-i]) begin
          grp_lz[g] = grp_lz[g] + 4'd1;
        end else begin
          found = 1'b1;
        end
      end
    end
  end

  // join bytes up to the first one holding a set bit
  always_comb begin
    logic done;
    done     = 1'b0;
    lz_total = '0;
    for (int g = 0; g < GRP_N; g++) begin
      if (!done) begin
        lz_total = lz_total + CntW'(s1_grp_lz_r[g]);
        if (s1_grp_lz_r[g] != 4'(GRP_W)) begin
          done = 1'b1;
        end
      end
    end
    rank_sum = lz_total + CntW'(1);
    rank     = (rank_sum > RankCap) ? RANK_W'(RankCap) : RANK_W'(rank_sum);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      if (s0_take) begin
        s0_valid_r <= in_valid && accept_en;
      end
      if (s1_ready) begin
        s1_valid_r <= s0_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s0_take) begin
      s0_hash_r <= in_hash_value;
    end
    if (s1_ready) begin
      s1_grp_lz_r <= grp_lz;
      s1_bucket_r <= s0_hash_r[Precision-1:0];
    end
  end

  assign q_valid = s1_valid_r;
  assign q_entry = '{bucket: PREC_MAX'(s1_bucket_r), rank: rank};

endmodule

// File: rtl/hllu_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hllu_queue
// two-entry queue between classification and the register store
// ----------------------------------------------------------------------------
module hllu_queue import hllu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push_valid,
  output logic        push_ready,
  input  hllu_entry_t push_entry,
  output logic        pop_valid,
  input  logic        pop_ready,
  output hllu_entry_t pop_entry
);

  hllu_entry_t slot_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  count_r;
  logic        push;
  logic        pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_entry  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// File: rtl/hllu_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hllu_back
// clears the rank store, then does read-compare-write per item and counts
// ----------------------------------------------------------------------------
module hllu_back import hllu_pkg::*; #(
  parameter int Precision = PREC_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  output logic                 clr_busy,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  hllu_entry_t          q_entry,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [BKT_OUT_W-1:0] out_bucket_index,
  output logic [RANK_W-1:0]    out_item_rank,
  output logic                 out_bucket_raised,
  output logic [CNT_W-1:0]     out_items_seen
);

  localparam int Depth = 1 << Precision;
  localparam int ExtW  = (Precision > BKT_OUT_W) ? Precision : BKT_OUT_W;

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_UPDATE} state_t;

  state_t               state_r;
  logic [Precision-1:0] clr_addr_r;
  logic [Precision-1:0] work_bucket_r;
  logic [RANK_W-1:0]    work_rank_r;
  logic [CNT_W-1:0]     item_cnt_r;
  logic                 out_valid_r;
  logic [BKT_OUT_W-1:0] out_bucket_r;
  logic [RANK_W-1:0]    out_rank_r;
  logic                 out_raised_r;
  logic [CNT_W-1:0]     out_count_r;

  logic [RANK_W-1:0]    store_mem [Depth];
  logic [RANK_W-1:0]    rd_data_r;
  logic [Precision-1:0] rd_addr;
  logic                 mem_we;
  logic [Precision-1:0] mem_waddr;
  logic [RANK_W-1:0]    mem_wdata;

  logic                 out_free;
  logic                 raised;
  logic                 finish;
  logic [ExtW-1:0]      bkt_ext;
  logic [CNT_W-1:0]     cnt_nxt;

  assign clr_busy = (state_r == ST_CLEAR);
  assign q_ready  = (state_r == ST_IDLE);
  assign out_free = !out_valid_r || out_ready;
  assign raised   = work_rank_r > rd_data_r;
  assign finish   = (state_r == ST_UPDATE) && out_free;
  assign bkt_ext  = ExtW'(work_bucket_r);
  assign cnt_nxt  = item_cnt_r + CNT_W'(1);
  assign rd_addr  = (state_r == ST_IDLE) ? q_entry.bucket[Precision-1:0] : work_bucket_r;

  // single write port shared by the clearing pass and the update
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = work_bucket_r;
    mem_wdata = work_rank_r;
    if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = '0;
    end else if (finish && raised) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= store_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      item_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ready && !finish) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_CLEAR: begin
          clr_addr_r <= clr_addr_r + Precision'(1);
          if (&clr_addr_r) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (q_valid) begin
            work_bucket_r <= q_entry.bucket[Precision-1:0];
            work_rank_r   <= q_entry.rank;
            state_r       <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (out_free) begin
            item_cnt_r   <= cnt_nxt;
            out_valid_r  <= 1'b1;
            out_bucket_r <= bkt_ext[BKT_OUT_W-1:0];
            out_rank_r   <= work_rank_r;
            out_raised_r <= raised;
            out_count_r  <= cnt_nxt;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_bucket_index  = out_bucket_r;
  assign out_item_rank     = out_rank_r;
  assign out_bucket_raised = out_raised_r;
  assign out_items_seen    = out_count_r;

endmodule

// File: rtl/hyperloglog_register_update_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hyperloglog_register_update_core
// hyperloglog bucket update: rank of a 64-bit hash, max into the rank store
// ----------------------------------------------------------------------------
//  channel | ports                                   | dir | item
//  --------+-----------------------------------------+-----+--------------------
//  input   | in_valid in_ready in_hash_value         | in  | one hash
//  result  | out_valid out_ready out_bucket_index    | out | bucket, rank,
//          | out_item_rank out_bucket_raised         |     | raised flag, count
//          | out_items_seen                          |     |
//
//  the rank store takes one item at a time: ST_IDLE reads the bucket, then
//  ST_UPDATE compares, writes and loads the output, waiting on a full output register
//  an accepted hash passes s0, s1, the queue and ST_IDLE/ST_UPDATE to the output
//  after reset a clearing pass zeroes all 2^Precision entries of the store
//  (16384 at the default); in_ready stays low until it is done
//  the 2-entry queue and the output register let either side stall alone
// ----------------------------------------------------------------------------
module hyperloglog_register_update_core import hllu_pkg::*; #(
  parameter int Precision = PREC_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [HASH_W-1:0]    in_hash_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [BKT_OUT_W-1:0] out_bucket_index,
  output logic [RANK_W-1:0]    out_item_rank,
  output logic                 out_bucket_raised,
  output logic [CNT_W-1:0]     out_items_seen
);

  localparam logic [RANK_W-1:0] RankCap = RANK_W'(HASH_W + 1 - Precision);

  // front to queue
  logic        fq_valid;
  logic        fq_ready;
  hllu_entry_t fq_entry;
  // queue to back
  logic        qb_valid;
  logic        qb_ready;
  hllu_entry_t qb_entry;
  // store clearing pass in progress
  logic        clr_busy;

  // classify: bucket from low bits, capped leading-zero rank from the rest
  hllu_front #(
    .Precision(Precision)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept_en    (!clr_busy),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_hash_value(in_hash_value),
    .q_valid      (fq_valid),
    .q_ready      (fq_ready),
    .q_entry      (fq_entry)
  );

  hllu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(fq_valid),
    .push_ready(fq_ready),
    .push_entry(fq_entry),
    .pop_valid (qb_valid),
    .pop_ready (qb_ready),
    .pop_entry (qb_entry)
  );

  // rank store update, item counter and output register
  hllu_back #(
    .Precision(Precision)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .clr_busy         (clr_busy),
    .q_valid          (qb_valid),
    .q_ready          (qb_ready),
    .q_entry          (qb_entry),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_bucket_index (out_bucket_index),
    .out_item_rank    (out_item_rank),
    .out_bucket_raised(out_bucket_raised),
    .out_items_seen   (out_items_seen)
  );

`ifndef ASSERT_OFF
  // no hash taken while the store is still being cleared
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> !in_ready)
    else $error("input accepted during clearing pass");

  // nothing can come out before the store is usable
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> !out_valid && !qb_valid)
    else $error("item in flight during clearing pass");

  // rank always within one and the cap
  a_rank_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item_rank != '0) && (out_item_rank <= RankCap))
    else $error("result rank out of range");
`endif

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for hyperloglog_register_update_core: a table of
// directed hashes, then about a thousand random ones under several idling
// and stall mixes; every result is compared against a typed expectation or a
// behavioral bucket model that keeps its own rank store and item count
// ----------------------------------------------------------------------------
module tb;
  import hllu_pkg::*;

  localparam int PREC         = PREC_DEFAULT;
  localparam int RANK_CAP     = HASH_W + 1 - PREC;   // 51 at the default
  localparam int SCAN_TOP     = HASH_W - 1 - PREC;   // highest hash bit that reaches the scan
  localparam int HOT_N        = 16;
  localparam int HOLD_CYCLES  = 400;
  localparam int PRESSURE_N   = 40;
  localparam int PHASE_N      = 250;
  localparam int DRAIN_CYCLES = 20;
  // worst quiet stretch is the store clearing pass after reset, then the long
  // receiver hold; several times that
  localparam int QUIET_LIMIT  = 4 * ((1 << PREC) + HOLD_CYCLES + 64);
  localparam int PRINT_MAX    = 30;

  // one expected result
  typedef struct packed {
    logic [BKT_OUT_W-1:0] bucket;
    logic [RANK_W-1:0]    rank;
    logic                 raised;
    logic [CNT_W-1:0]     seen;
  } hll_result_t;

  // one directed row; fixed_exp says the expectation is typed in below
  typedef struct packed {
    logic [HASH_W-1:0] hash;
    logic              fixed_exp;
    hll_result_t       want;
  } dir_row_t;

  localparam int DIR_N = 17;
  localparam dir_row_t DIRECTED [DIR_N] = '{
    // all zero: bucket 0, capped rank, first write raises it
    '{64'h0000_0000_0000_0000, 1'b1, '{14'h0000, 6'd51, 1'b1, 32'd1}},
    // all ones: top bucket, scanned top bit set so rank 1
    '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{14'h3FFF, 6'd1, 1'b1, 32'd2}},
    // same capped rank again on bucket 0: equal rank keeps the store
    '{64'h0000_0000_0000_0000, 1'b1, '{14'h0000, 6'd51, 1'b0, 32'd3}},
    // bits shifted out of the scan window only
    '{64'h8000_0000_0000_0000, 1'b0, '0},
    '{64'hFFFC_0000_0000_0000, 1'b0, '0},
    // bucket 7: rank 2 then a rank 1 hash that must not raise
    '{64'h0001_0000_0000_0007, 1'b0, '0},
    '{64'h0002_0000_0000_0007, 1'b0, '0},
    '{64'h0000_0000_0000_2007, 1'b0, '0},
    '{64'h0000_0000_0000_0001, 1'b0, '0},
    '{64'h0000_0000_0000_3FFE, 1'b0, '0},
    // bucket 0x1234 at falling ranks, only the first raises
    '{64'h0000_0000_4000_1234, 1'b0, '0},
    '{64'h0000_0001_0000_1234, 1'b0, '0},
    '{64'h0000_8000_0000_1234, 1'b0, '0},
    '{64'h0000_0000_0000_4000, 1'b0, '0},
    '{64'h5555_5555_5555_5555, 1'b0, '0},
    '{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0},
    '{64'h0000_0000_0000_3FFF, 1'b0, '0}
  };

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [HASH_W-1:0]    in_hash_value = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [BKT_OUT_W-1:0] out_bucket_index;
  logic [RANK_W-1:0]    out_item_rank;
  logic                 out_bucket_raised;
  logic [CNT_W-1:0]     out_items_seen;

  // behavioral copy of the block state
  logic [RANK_W-1:0] shadow_ranks [1 << PREC];
  logic [CNT_W-1:0]  shadow_count;
  hll_result_t       expected_updates [$];

  // a few buckets that the random part hits over and over, so raises and
  // equal or lower ranks on a warm bucket both show up
  logic [PREC-1:0]   hot_buckets [HOT_N];

  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  int hold_token    = 0;   // bumped by the stimulus to ask for a long hold
  int hold_seen     = 0;
  int hold_left     = 0;

  int items_sent      = 0;
  int results_checked = 0;
  int raises_seen     = 0;
  int mismatches      = 0;
  int quiet_cycles    = 0;

  hyperloglog_register_update_core #(
    .Precision(PREC)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_hash_value    (in_hash_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_bucket_index (out_bucket_index),
    .out_item_rank    (out_item_rank),
    .out_bucket_raised(out_bucket_raised),
    .out_items_seen   (out_items_seen)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // rank of one hash against the shadow store: the hash is shifted left by
  // the precision, leading zeros counted plus one and capped, and the bucket
  // raised when the new rank is strictly larger
  function automatic hll_result_t predict_bucket_update(input logic [HASH_W-1:0] h);
    logic [PREC-1:0]   bkt;
    logic [HASH_W-1:0] scan;
    int                r;
    hll_result_t       res;
    bkt  = h[PREC-1:0];
    scan = h << PREC;
    r    = 1;
    while (r < RANK_CAP && !scan[HASH_W-1]) begin
      r++;
      scan = scan << 1;
    end
    res.raised = (r > int'(shadow_ranks[bkt]));
    if (res.raised) begin
      shadow_ranks[bkt] = RANK_W'(r);
    end
    shadow_count = shadow_count + 1'b1;
    res.bucket   = BKT_OUT_W'(bkt);
    res.rank     = RANK_W'(r);
    res.seen     = shadow_count;
    return res;
  endfunction

  // random hash: a quarter plain uniform, the rest with a chosen number of
  // leading zeros in the scanned window so every rank comes up
  function automatic logic [HASH_W-1:0] make_hash();
    logic [HASH_W-1:0] h;
    int                z;
    h = {$urandom, $urandom};
    if ($urandom_range(0, 3) != 0) begin
      z = $urandom_range(0, SCAN_TOP + 1);
      h[SCAN_TOP:0] = h[SCAN_TOP:0] >> z;
      if (z <= SCAN_TOP) begin
        h[SCAN_TOP - z] = 1'b1;
      end
    end
    if ($urandom_range(0, 1) != 0) begin
      h[PREC-1:0] = hot_buckets[$urandom_range(0, HOT_N - 1)];
    end
    return h;
  endfunction

  // offer one hash, hold it until accepted, then queue what it should give;
  // valid is only lowered when an idle cycle is actually taken
  task automatic send_hash(input logic [HASH_W-1:0] h, input logic fixed_exp,
                           input hll_result_t want);
    hll_result_t predicted;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_hash_value <= h;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = predict_bucket_update(h);
    expected_updates.push_back(fixed_exp ? want : predicted);
    items_sent++;
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatches < PRINT_MAX) begin
      $display("%0t mismatch on result %0d: %s got 0x%0h expected 0x%0h",
               $realtime, results_checked, what, got, want);
    end
    mismatches++;
  endtask

  // receiver: random stalls at the phase rate, or a long hold when asked
  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  // result checker: every accepted result against the oldest expectation
  always @(posedge clk) begin
    hll_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_updates.size() == 0) begin
        report_mismatch("result with nothing pending", 64'(out_items_seen), 64'h0);
      end else begin
        want = expected_updates.pop_front();
        if (out_bucket_index !== want.bucket)
          report_mismatch("bucket_index", 64'(out_bucket_index), 64'(want.bucket));
        if (out_item_rank !== want.rank)
          report_mismatch("item_rank", 64'(out_item_rank), 64'(want.rank));
        if (out_bucket_raised !== want.raised)
          report_mismatch("bucket_raised", 64'(out_bucket_raised), 64'(want.raised));
        if (out_items_seen !== want.seen)
          report_mismatch("items_seen", 64'(out_items_seen), 64'(want.seen));
        if (want.raised) raises_seen++;
        results_checked++;
      end
    end
  end

  // watchdog: too long without any item moving on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: %0d cycles with no item moving, %0d results pending",
               quiet_cycles, expected_updates.size());
      $display("** hyperloglog_register_update_core: FAILED **");
      $finish;
    end
  end

  initial begin
    foreach (shadow_ranks[i]) shadow_ranks[i] = '0;
    shadow_count = '0;
    foreach (hot_buckets[i]) hot_buckets[i] = PREC'($urandom);

    // reset once; the block then clears its store before taking items
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed table, no idling on either side
    for (int i = 0; i < DIR_N; i++) begin
      send_hash(DIRECTED[i].hash, DIRECTED[i].fixed_exp, DIRECTED[i].want);
    end

    // back pressure: receiver holds off while hashes keep coming
    hold_token <= hold_token + 1;
    repeat (PRESSURE_N) send_hash(make_hash(), 1'b0, '0);

    // random phases: none, sender idle, receiver stall, both light
    for (int ph = 0; ph < 4; ph++) begin
      unique case (ph)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 68; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 68; end
        default: begin src_idle_pct = 7; snk_stall_pct = 7; end
      endcase
      repeat (PHASE_N) send_hash(make_hash(), 1'b0, '0);
    end
    in_valid <= 1'b0;

    // drain what is still in flight, then a few more cycles for stray output
    snk_stall_pct = 0;
    while (expected_updates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d hashes (%0d from the directed table), %0d results checked",
             items_sent, DIR_N, results_checked);
    $display("%0d bucket raises, long receiver hold and four idle mixes, %0d mismatches",
             raises_seen, mismatches);
    if (mismatches == 0) begin
      $display("** hyperloglog_register_update_core: PASSED **");
    end else begin
      $display("** hyperloglog_register_update_core: FAILED **");
    end
    $finish;
  end

endmodule
